/* design/dpft_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpft_pkg
// Shared types and constants of the dated price floor table.
// ----------------------------------------------------------------------------
package dpft_pkg;

  localparam int YEAR_W  = 14;
  localparam int MD_W    = 7;
  localparam int PRICE_W = 32;
  localparam int KEY_W   = 23;

  // Packed date key: year, 4-bit month, 5-bit day
  localparam int KEY_MON_W = 4;
  localparam int KEY_DAY_W = 5;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = 14'd2009;

  // y % 25 == 0  <=>  (y * ceil(2^24/25)) mod 2^24 < ceil(2^24/25), y < 2^14
  localparam int                    DIV25_SHIFT = 24;
  localparam logic [DIV25_SHIFT-1:0] DIV25_MUL  = 24'd671089;

  // Reduction tree: fan-in of 2**TREE_FANIN_LOG per registered level
  localparam int TREE_FANIN_LOG = 4;

  typedef enum logic [2:0] {
    ST_EXACT   = 3'd0,
    ST_EARLIER = 3'd1,
    ST_INVALID = 3'd2,
    ST_NONE    = 3'd3,
    ST_FULL    = 3'd4,
    ST_STORED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_WAIT,
    S_COMMIT
  } state_e;

  typedef struct packed {
    logic                      eq;
    logic signed [PRICE_W-1:0] price;
  } leaf_t;

  function automatic int tree_levels(input int leaves);
    int lg;
    lg = $clog2(leaves);
    if (lg < 1) lg = 1;
    return (lg + TREE_FANIN_LOG - 1) / TREE_FANIN_LOG;
  endfunction

endpackage

/* design/dpft_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpft_cell
// One table slot: holds a date key and price, compares against the request
// key and shifts up from its lower neighbor on an insert.
// ----------------------------------------------------------------------------
module dpft_cell
  import dpft_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic                      capture_i,
  input  logic                      shift_i,
  input  logic                      overwrite_i,
  input  logic [KEY_W-1:0]          key_i,
  input  logic signed [PRICE_W-1:0] price_i,
  input  logic                      left_le_i,
  input  logic [KEY_W-1:0]          left_key_i,
  input  logic signed [PRICE_W-1:0] left_price_i,
  input  logic                      right_le_i,
  output logic                      le_o,
  output logic [KEY_W-1:0]          key_o,
  output logic signed [PRICE_W-1:0] price_o,
  output leaf_t                     leaf_o
);

  logic                      le_q, eq_q;
  logic [KEY_W-1:0]          key_q;
  logic signed [PRICE_W-1:0] price_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      le_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (capture_i) begin
      le_q <= valid_i && (key_q <= key_i);
      eq_q <= valid_i && (key_q == key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (overwrite_i && eq_q) begin
      price_q <= price_i;
    end else if (shift_i && !le_q) begin
      // first slot above the floor takes the new entry, the rest move up
      if (left_le_i) begin
        key_q   <= key_i;
        price_q <= price_i;
      end else begin
        key_q   <= left_key_i;
        price_q <= left_price_i;
      end
    end
  end

  assign le_o    = le_q;
  assign key_o   = key_q;
  assign price_o = price_q;

  always_comb begin
    leaf_o = '0;
    if (le_q && !right_le_i) begin
      leaf_o.eq    = eq_q;
      leaf_o.price = price_q;
    end
  end

endmodule

/* design/dpft_or_tree.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpft_or_tree
// Registered OR reduction of one-hot leaves, one register per level.
// ----------------------------------------------------------------------------
module dpft_or_tree
  import dpft_pkg::*;
#(
  parameter int WIDTH  = 33,
  parameter int LEAVES = 1024
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] leaf_i [LEAVES],
  output logic [WIDTH-1:0] root_o
);

  localparam int LEVELS = tree_levels(LEAVES);
  localparam int FANIN  = 1 << TREE_FANIN_LOG;
  localparam int PADDED = 1 << (TREE_FANIN_LOG * LEVELS);

  // Base of each registered level in the flat node array
  function automatic int lvl_off(input int lv);
    int acc;
    acc = 0;
    for (int k = 1; k < lv; k++) acc += PADDED >> (TREE_FANIN_LOG * k);
    return acc;
  endfunction

  localparam int NODES = lvl_off(LEVELS + 1);

  logic [WIDTH-1:0] leaves [PADDED];
  logic [WIDTH-1:0] node_q [NODES];

  for (genvar i = 0; i < PADDED; i++) begin : g_pad
    if (i < LEAVES) begin : g_real
      assign leaves[i] = leaf_i[i];
    end else begin : g_zero
      assign leaves[i] = '0;
    end
  end

  for (genvar lv = 1; lv <= LEVELS; lv++) begin : g_lvl
    localparam int CNT  = PADDED >> (TREE_FANIN_LOG * lv);
    localparam int OFF  = lvl_off(lv);
    localparam int POFF = lvl_off(lv - 1);
    for (genvar n = 0; n < CNT; n++) begin : g_node
      logic [WIDTH-1:0] acc;
      if (lv == 1) begin : g_first
        always_comb begin
          acc = '0;
          for (int c = 0; c < FANIN; c++) acc = acc | leaves[n*FANIN + c];
        end
      end else begin : g_upper
        always_comb begin
          acc = '0;
          for (int c = 0; c < FANIN; c++) acc = acc | node_q[POFF + n*FANIN + c];
        end
      end
      always_ff @(posedge clk_i) begin
        node_q[OFF + n] <= acc;
      end
    end
  end

  assign root_o = node_q[lvl_off(LEVELS)];

endmodule

/* design/dated_price_floor_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dated_price_floor_table
// Date-ordered price table with insert and floor lookup on a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one request: tuser = func (0 insert, 1 lookup),
//   tdata = year, month, day, price. Master stream returns one result per
//   request: tdata = price (zero unless a lookup found an entry), tuser =
//   status (exact, earlier, invalid date, no earlier data, full, stored).
//   The config channel writes min_year, the earliest valid year; write it
//   only while no request is in flight.
//   Every table slot is a cell holding key and price. A request is latched,
//   all cells compare their key against it at once, then the floor
//   cell (last one not above the key, found from its right neighbor) feeds
//   a registered OR tree of fan-in 16. On commit an insert overwrites the
//   matching cell or moves every cell above the floor up by one.
//   A new request is accepted only after the previous one commits. Between
//   acceptance and a valid result lie the request register, the cell compare
//   registers, LEVELS tree levels (3 at 1024 entries) and the output register.
//   Reset empties the table (fill count zero), restores min_year to 2009.
//   A result waits in the output register while the receiver stalls; the
//   next request is still accepted and holds at commit until that slot
//   frees.
// ----------------------------------------------------------------------------
module dated_price_floor_table
  import dpft_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // year[13:0], month[20:14], day[27:21],
                                      // price_in[59:28], zero[63:60]
  input  logic        s_axis_tuser,   // func[0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // price_out[31:0]
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  // min_year register
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [YEAR_W-1:0] cfg_data_i
);

  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int LEVELS = tree_levels(TABLE_DEPTH);
  localparam int WAIT_W = $clog2(LEVELS + 1);
  localparam int LEAF_W = $bits(leaf_t);

  state_e state_q, state_d;
  logic [WAIT_W-1:0] wait_q, wait_d;
  logic [CNT_W-1:0]  count_q;
  logic [YEAR_W-1:0] min_year_q;

  // latched request
  logic                      func_q;
  logic [YEAR_W-1:0]         year_q;
  logic [MD_W-1:0]           month_q, day_q;
  logic signed [PRICE_W-1:0] price_q;
  logic                      date_ok_q;
  logic [KEY_W-1:0]          key;

  // output register
  logic                      out_valid_q;
  logic signed [PRICE_W-1:0] out_price_q;
  status_e                   out_status_q;

  logic accept, out_free, commit, capture, shift_en, overwrite_en, full;
  logic date_ok, leap, div25;
  logic [MD_W-1:0]        last_day;
  logic [DIV25_SHIFT-1:0] year_frac;
  status_e                status;

  // cell chain wiring
  logic                      le_w    [TABLE_DEPTH];
  logic [KEY_W-1:0]          key_w   [TABLE_DEPTH];
  logic signed [PRICE_W-1:0] price_w [TABLE_DEPTH];
  leaf_t                     leaf_w  [TABLE_DEPTH];
  logic [LEAF_W-1:0]         leaf_v  [TABLE_DEPTH];
  logic [LEAF_W-1:0]         root_v;
  leaf_t                     root;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign commit        = (state_q == S_COMMIT) && out_free;
  assign capture       = (state_q == S_CMP);
  assign full          = (count_q == CNT_W'(TABLE_DEPTH));

  assign key = {year_q, month_q[KEY_MON_W-1:0], day_q[KEY_DAY_W-1:0]};

  // ---- sequencer ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wait_q  <= '0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
    end
  end

  always_comb begin
    state_d = state_q;
    wait_d  = wait_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_CMP;
      end
      S_CMP: begin
        // cells latch their compare, then wait out the tree
        state_d = S_WAIT;
        wait_d  = WAIT_W'(LEVELS - 1);
      end
      S_WAIT: begin
        if (wait_q == '0) state_d = S_COMMIT;
        else              wait_d  = wait_q - 1'b1;
      end
      S_COMMIT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---- config and request registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q <= MIN_YEAR_RESET;
    end else if (cfg_valid_i) begin
      min_year_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= s_axis_tuser;
      year_q  <= s_axis_tdata[13:0];
      month_q <= s_axis_tdata[20:14];
      day_q   <= s_axis_tdata[27:21];
      price_q <= s_axis_tdata[59:28];
    end
    if (capture) date_ok_q <= date_ok;
  end

  // ---- date check ----
  // divisible by 25 through a reciprocal multiply, by 4 and 16 through masks
  assign year_frac = DIV25_SHIFT'(year_q) * DIV25_MUL;
  assign div25     = (year_frac < DIV25_MUL);
  assign leap      = (year_q[1:0] == 2'b00) && (!div25 || (year_q[3:0] == 4'b0000));

  always_comb begin
    case (month_q)
      7'd2:                         last_day = leap ? 7'd29 : 7'd28;
      7'd4, 7'd6, 7'd9, 7'd11:      last_day = 7'd30;
      default:                      last_day = 7'd31;
    endcase
    date_ok = (year_q >= min_year_q) && (month_q >= 7'd1) && (month_q <= 7'd12)
              && (day_q >= 7'd1) && (day_q <= last_day);
  end

  // ---- commit decisions ----
  assign root = leaf_t'(root_v);

  assign overwrite_en = commit && date_ok_q && (func_q == FUNC_INSERT) && root.eq;
  assign shift_en     = commit && date_ok_q && (func_q == FUNC_INSERT) && !root.eq
                        && !full;

  always_comb begin
    if (!date_ok_q)                 status = ST_INVALID;
    else if (func_q == FUNC_INSERT) status = (root.eq || !full) ? ST_STORED : ST_FULL;
    else if (!le_w[0])              status = ST_NONE;
    else if (root.eq)               status = ST_EXACT;
    else                            status = ST_EARLIER;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (shift_en) count_q <= count_q + 1'b1;
      if (commit)             out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_status_q <= status;
      // hand out the price only for a lookup that found an entry
      out_price_q  <= (status == ST_EXACT || status == ST_EARLIER) ? root.price : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_price_q;
  assign m_axis_tuser  = out_status_q;

  // ---- row of cells ----
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                      left_le, right_le;
    logic [KEY_W-1:0]          left_key;
    logic signed [PRICE_W-1:0] left_price;

    if (i == 0) begin : g_first
      assign left_le    = 1'b1;
      assign left_key   = '0;
      assign left_price = '0;
    end else begin : g_mid
      assign left_le    = le_w[i-1];
      assign left_key   = key_w[i-1];
      assign left_price = price_w[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_le = 1'b0;
    end else begin : g_inner
      assign right_le = le_w[i+1];
    end

    dpft_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .valid_i      (CNT_W'(i) < count_q),
      .capture_i    (capture),
      .shift_i      (shift_en),
      .overwrite_i  (overwrite_en),
      .key_i        (key),
      .price_i      (price_q),
      .left_le_i    (left_le),
      .left_key_i   (left_key),
      .left_price_i (left_price),
      .right_le_i   (right_le),
      .le_o         (le_w[i]),
      .key_o        (key_w[i]),
      .price_o      (price_w[i]),
      .leaf_o       (leaf_w[i])
    );

    assign leaf_v[i] = leaf_w[i];
  end

  dpft_or_tree #(
    .WIDTH  (LEAF_W),
    .LEAVES (TABLE_DEPTH)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (leaf_v),
    .root_o (root_v)
  );

  // ---- assertions ----
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("fill count past table depth");

  a_shift_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_en |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the table");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && status == ST_FULL |-> full && !shift_en)
    else $error("full reported with free slots");

  a_zero_price : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != ST_EXACT && out_status_q != ST_EARLIER
      |-> out_price_q == '0)
    else $error("non-lookup result carries a price");

endmodule
